### hdl/edge_length_constraint_projection_unit_macros.svh
// Assertion macros for the edge length constraint projection unit.
// Used by the port checker; no other dependencies.
`ifndef EDGE_LENGTH_CONSTRAINT_PROJECTION_UNIT_MACROS_SVH
`define EDGE_LENGTH_CONSTRAINT_PROJECTION_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ELCP_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elcp check failed");

// Next-cycle implication, off during reset.
`define ELCP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elcp check failed");

// Next-cycle implication that also holds around reset.
`define ELCP_ASSERT_RAW(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("elcp check failed");

`endif

### hdl/elcp_pkg.sv
// Shared types, constants and helpers for the edge length constraint projection unit.
// No dependencies.
`timescale 1ns / 1ps

package elcp_pkg;

  localparam int SQ_STEPS    = 33;  // two radicand bits per step, 66-bit radicand
  localparam int DIV_STEPS   = 31;  // quotient bits of the direction divide
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [19:0]        first_index;
    logic [19:0]        second_index;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        rest_len;
    logic [30:0]        weight;
  } in_item_t;

  typedef struct packed {
    logic [19:0]        out_first_index;
    logic [19:0]        out_second_index;
    logic signed [31:0] proj_first_x;
    logic signed [31:0] proj_first_y;
    logic signed [31:0] proj_first_z;
    logic signed [31:0] proj_second_x;
    logic signed [31:0] proj_second_y;
    logic signed [31:0] proj_second_z;
    logic signed [31:0] rhs_x;
    logic signed [31:0] rhs_y;
    logic signed [31:0] rhs_z;
  } out_item_t;

  // Classified edge: endpoints, edge magnitudes and signs, rest length, weight.
  typedef struct packed {
    logic [19:0]       first_index;
    logic [19:0]       second_index;
    logic [2:0][31:0]  a;
    logic [2:0][31:0]  b;
    logic [2:0][31:0]  dmag;
    logic [2:0]        dneg;
    logic [30:0]       rest;
    logic [30:0]       wgt;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [65:0] sum_sq;
  } qent_t;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) r = 32'h7fffffff;
    else if (v < -35'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### hdl/elcp_front.sv
// Front part: accepts requests, forms edge vectors and the squared length.
// Depends on elcp_pkg.
`timescale 1ns / 1ps

module elcp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  elcp_pkg::in_item_t in_item,
  output logic             push,
  output elcp_pkg::qent_t  push_data,
  input  logic             full
);

  elcp_pkg::ctx_t     ctx_in;
  logic [2:0][31:0]   ain, bin;
  logic signed [32:0] dif [3];
  logic               fe;

  logic               v1, v2, v3;
  elcp_pkg::ctx_t     c1, c2, c3;
  logic [2:0][63:0]   sq2;
  logic [65:0]        sum3;

  assign ain = {in_item.first_z, in_item.first_y, in_item.first_x};
  assign bin = {in_item.second_z, in_item.second_y, in_item.second_x};

  always_comb begin
    ctx_in.first_index  = in_item.first_index;
    ctx_in.second_index = in_item.second_index;
    ctx_in.a    = ain;
    ctx_in.b    = bin;
    ctx_in.rest = in_item.rest_len;
    ctx_in.wgt  = in_item.weight;
    for (int i = 0; i < 3; i++) begin
      dif[i] = $signed({bin[i][31], bin[i]}) - $signed({ain[i][31], ain[i]});
      ctx_in.dneg[i] = dif[i][32];
      ctx_in.dmag[i] = dif[i][32] ? 32'(-dif[i]) : dif[i][31:0];
    end
  end

  // hold the whole front while the last stage waits on a full queue
  assign fe        = !v3 || !full;
  assign in_ready  = fe;
  assign push      = v3 && !full;
  assign push_data = '{ctx: c3, sum_sq: sum3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (fe) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (fe) begin
      c1 <= ctx_in;
      c2 <= c1;
      for (int i = 0; i < 3; i++) sq2[i] <= c1.dmag[i] * c1.dmag[i];
      c3   <= c2;
      sum3 <= {2'b00, sq2[0]} + {2'b00, sq2[1]} + {2'b00, sq2[2]};
    end
  end

endmodule

### hdl/elcp_queue.sv
// Short queue between the front and back parts.
// Depends on elcp_pkg.
`timescale 1ns / 1ps

module elcp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  elcp_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output elcp_pkg::qent_t pop_data
);

  elcp_pkg::qent_t             mem [elcp_pkg::QUEUE_DEPTH];
  logic [elcp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [elcp_pkg::QPTR_W:0]   count;

  assign full     = count == (elcp_pkg::QPTR_W + 1)'(elcp_pkg::QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

### hdl/elcp_back.sv
// Back part: pipelined square root, direction divide, correction and rhs terms.
// Depends on elcp_pkg.
`timescale 1ns / 1ps

module elcp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  elcp_pkg::qent_t    q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output elcp_pkg::out_item_t out_item
);

  localparam int NS = elcp_pkg::SQ_STEPS;
  localparam int ND = elcp_pkg::DIV_STEPS;

  logic be;
  assign be  = !out_valid || out_ready;
  assign pop = be && q_valid;

  // ---- square root, two radicand bits per stage ----
  logic           sq_v    [NS+1];
  elcp_pkg::ctx_t sq_ctx  [NS+1];
  logic [65:0]    sq_rad  [NS+1];
  logic [34:0]    sq_rem  [NS+1];
  logic [32:0]    sq_root [NS+1];

  assign sq_v[0]    = q_valid;
  assign sq_ctx[0]  = q_data.ctx;
  assign sq_rad[0]  = q_data.sum_sq;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sq
    logic [36:0] tmp, trial, dif;
    logic        take;
    assign tmp   = {sq_rem[k], sq_rad[k][65:64]};
    assign trial = {2'b00, sq_root[k], 2'b01};
    assign dif   = tmp - trial;
    assign take  = tmp >= trial;
    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (be) sq_v[k+1] <= sq_v[k];
      if (be) begin
        sq_ctx[k+1]  <= sq_ctx[k];
        sq_rad[k+1]  <= {sq_rad[k][63:0], 2'b00};
        sq_rem[k+1]  <= take ? dif[34:0] : tmp[34:0];
        sq_root[k+1] <= {sq_root[k][31:0], take};
      end
    end
  end

  // ---- length error and divide numerators ----
  logic [32:0]        len;
  logic signed [33:0] delta;
  logic [2:0][62:0]   num;

  assign len   = sq_root[NS];
  assign delta = $signed({1'b0, len}) - $signed({3'b000, sq_ctx[NS].rest});
  always_comb begin
    for (int i = 0; i < 3; i++)
      num[i] = {1'b0, sq_ctx[NS].dmag[i], 30'b0} + {31'b0, len[32:1]};
  end

  logic           pr_v;
  elcp_pkg::ctx_t pr_ctx;
  logic [32:0]    pr_len, pr_dm;
  logic           pr_dneg, pr_lz;
  logic [2:0][62:0] pr_num;

  always_ff @(posedge clk) begin
    if (rst) pr_v <= 1'b0;
    else if (be) pr_v <= sq_v[NS];
    if (be) begin
      pr_ctx  <= sq_ctx[NS];
      pr_len  <= len;
      pr_num  <= num;
      pr_dneg <= delta[33];
      pr_dm   <= delta[33] ? 33'(-delta) : delta[32:0];
      pr_lz   <= len == '0;
    end
  end

  // ---- restoring divide, one quotient bit per stage, three lanes ----
  logic             dv_v    [ND+1];
  elcp_pkg::ctx_t   dv_ctx  [ND+1];
  logic [32:0]      dv_len  [ND+1];
  logic [32:0]      dv_dm   [ND+1];
  logic             dv_dneg [ND+1];
  logic             dv_lz   [ND+1];
  logic [2:0][33:0] dv_rem  [ND+1];
  logic [2:0][30:0] dv_low  [ND+1];
  logic [2:0][30:0] dv_quo  [ND+1];

  assign dv_v[0]    = pr_v;
  assign dv_ctx[0]  = pr_ctx;
  assign dv_len[0]  = pr_len;
  assign dv_dm[0]   = pr_dm;
  assign dv_dneg[0] = pr_dneg;
  assign dv_lz[0]   = pr_lz;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = {2'b00, pr_num[i][62:31]};
      dv_low[0][i] = pr_num[i][30:0];
      dv_quo[0][i] = '0;
    end
  end

  for (genvar t = 0; t < ND; t++) begin : g_dv
    logic [2:0][33:0] tr, sub;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tr[i]  = {dv_rem[t][i][32:0], dv_low[t][i][30]};
        ge[i]  = tr[i] >= {1'b0, dv_len[t]};
        sub[i] = tr[i] - {1'b0, dv_len[t]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[t+1] <= 1'b0;
      else if (be) dv_v[t+1] <= dv_v[t];
      if (be) begin
        dv_ctx[t+1]  <= dv_ctx[t];
        dv_len[t+1]  <= dv_len[t];
        dv_dm[t+1]   <= dv_dm[t];
        dv_dneg[t+1] <= dv_dneg[t];
        dv_lz[t+1]   <= dv_lz[t];
        for (int i = 0; i < 3; i++) begin
          dv_rem[t+1][i] <= ge[i] ? sub[i] : tr[i];
          dv_low[t+1][i] <= {dv_low[t][i][29:0], 1'b0};
          dv_quo[t+1][i] <= {dv_quo[t][i][29:0], ge[i]};
        end
      end
    end
  end

  // ---- correction, projection, rhs ----
  logic             ml_v, cr_v, df_v, rp_v;
  elcp_pkg::ctx_t   ml_ctx, cr_ctx;
  logic [2:0][63:0] ml_prod, rp_prod;
  logic [2:0]       ml_neg, df_neg, rp_neg;
  logic [2:0][31:0] cr_pf, cr_ps, df_pf, df_ps, rp_pf, rp_ps;
  logic [2:0][32:0] df_mag;
  logic [30:0]      df_wgt;
  logic [19:0]      df_i1, df_i2, rp_i1, rp_i2;

  logic [2:0][63:0]   rnd;
  logic [2:0][34:0]   corr;
  logic signed [32:0] dd [3];
  logic [2:0][64:0]   rs;
  logic [2:0][47:0]   rmag;
  logic [2:0][31:0]   rhs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = ml_prod[i] + (64'd1 << 30);
      corr[i] = ml_neg[i] ? 35'(-{2'b00, rnd[i][63:31]}) : {2'b00, rnd[i][63:31]};
      dd[i]   = $signed({cr_pf[i][31], cr_pf[i]}) - $signed({cr_ps[i][31], cr_ps[i]});
      rs[i]   = {1'b0, rp_prod[i]} + 65'd65536;
      rmag[i] = rs[i][64:17];
      if (rp_neg[i]) rhs[i] = (rmag[i] > 48'd2147483648) ? 32'h80000000 : 32'(-rmag[i]);
      else rhs[i] = (rmag[i] > 48'd2147483647) ? 32'h7fffffff : rmag[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ml_v <= 1'b0;
      cr_v <= 1'b0;
      df_v <= 1'b0;
      rp_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (be) begin
      ml_v <= dv_v[ND];
      cr_v <= ml_v;
      df_v <= cr_v;
      rp_v <= df_v;
      out_valid <= rp_v;
    end
    if (be) begin
      ml_ctx <= dv_ctx[ND];
      for (int i = 0; i < 3; i++) begin
        // drop the correction on a zero-length edge
        ml_prod[i] <= dv_lz[ND] ? 64'd0 : dv_dm[ND] * dv_quo[ND][i];
        ml_neg[i]  <= dv_dneg[ND] ^ dv_ctx[ND].dneg[i];
      end
      cr_ctx <= ml_ctx;
      for (int i = 0; i < 3; i++) begin
        cr_pf[i] <= elcp_pkg::sat32($signed({{3{ml_ctx.a[i][31]}}, ml_ctx.a[i]})
                                    + $signed(corr[i]));
        cr_ps[i] <= elcp_pkg::sat32($signed({{3{ml_ctx.b[i][31]}}, ml_ctx.b[i]})
                                    - $signed(corr[i]));
      end
      df_i1  <= cr_ctx.first_index;
      df_i2  <= cr_ctx.second_index;
      df_wgt <= cr_ctx.wgt;
      df_pf  <= cr_pf;
      df_ps  <= cr_ps;
      for (int i = 0; i < 3; i++) begin
        df_neg[i] <= dd[i][32];
        df_mag[i] <= dd[i][32] ? 33'(-dd[i]) : dd[i];
      end
      rp_i1  <= df_i1;
      rp_i2  <= df_i2;
      rp_pf  <= df_pf;
      rp_ps  <= df_ps;
      rp_neg <= df_neg;
      for (int i = 0; i < 3; i++) rp_prod[i] <= df_mag[i] * df_wgt;
      out_item.out_first_index  <= rp_i1;
      out_item.out_second_index <= rp_i2;
      out_item.proj_first_x  <= rp_pf[0];
      out_item.proj_first_y  <= rp_pf[1];
      out_item.proj_first_z  <= rp_pf[2];
      out_item.proj_second_x <= rp_ps[0];
      out_item.proj_second_y <= rp_ps[1];
      out_item.proj_second_z <= rp_ps[2];
      out_item.rhs_x <= rhs[0];
      out_item.rhs_y <= rhs[1];
      out_item.rhs_z <= rhs[2];
    end
  end

endmodule

### hdl/edge_length_constraint_projection_unit.sv
// Edge length constraint projection unit takes one edge per cycle while in_ready is high and
// returns one result per edge, in order. The path runs through 3 front stages, the queue, 33
// square-root stages (two radicand bits each), one length-error stage, 31 divide stages (one
// quotient bit each, three lanes) and 5 stages of correction, projection and rhs arithmetic.
// Sustained rate is one request per cycle; the back pipeline holds while out_ready is low and
// the 4-entry queue then absorbs the front's work before in_ready drops.
// Depends on elcp_pkg, elcp_front, elcp_queue, elcp_back.
`timescale 1ns / 1ps

module edge_length_constraint_projection_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  elcp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output elcp_pkg::out_item_t out_item
);

  logic            push, full, pop, nonempty;
  elcp_pkg::qent_t push_data, pop_data;

  elcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  elcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_data  (pop_data)
  );

  elcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (nonempty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### hdl/elcp_checker.sv
// Port checker for the edge length constraint projection unit, bound to the top level.
// Depends on elcp_pkg and edge_length_constraint_projection_unit_macros.svh.
`timescale 1ns / 1ps
`include "edge_length_constraint_projection_unit_macros.svh"

module elcp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input elcp_pkg::out_item_t out_item
);

  `ELCP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ELCP_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_item))
  `ELCP_ASSERT_RAW(a_rst_clears, clk, rst, !out_valid)
  `ELCP_ASSERT_RAW(a_rst_ready, clk, rst, in_ready)
  `ELCP_ASSERT_IMP(a_rhs_zero_x, clk, rst,
                   out_valid && out_item.proj_first_x == out_item.proj_second_x,
                   out_item.rhs_x == 32'd0)

endmodule

bind edge_length_constraint_projection_unit elcp_checker u_elcp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
